### rtl/core/scm_pkg.sv
// Shared types and constants for the stereo correlation meter.
package scm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 41;
   localparam int PROD_W   = 82;
   localparam int NUM_W    = 111;
   localparam int COEF_W   = 16;
   localparam logic [31:0] SILENCE_RESET = 32'd1152921505;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       last_in_window;
   } req_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] correlation;
      logic                     silent;
   } rsp_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] cross_sum;
      logic [SUM_W-1:0]        left_energy;
      logic [SUM_W-1:0]        right_energy;
   } window_type;

endpackage

### rtl/core/stereo_correlation_meter.sv
// Top level of the stereo correlation meter.
// Usage:
//   req channel: one left/right sample pair per transfer; last_in_window closes
//   the window. Pairs are taken one per cycle while the window queue has room.
//   rsp channel: one result per closed window: correlation in Q1.15
//   (32767 = 1.0) and a silent flag.
//   csr channel: write of silence_limit, always ready; write only while idle.
// Back end: a closed window passes through two digit-serial multiplies, a
//   31-step divide and a 16-step square root before rsp_valid rises; silent
//   or zero-energy windows and saturating quotients skip the later steps. The
//   back end solves one window at a time; QUEUE_DEPTH closed windows may wait.
// Throughput: one sample pair per cycle while the queue has room; the back end
//   takes a new window only after the receiver has taken the last result.
// Reset clears the sums, the queue and the solver, and loads silence_limit
// with its default. While rsp_ready is low the result holds; the front keeps
// accumulating until the queue fills, then drops req_ready.
module stereo_correlation_meter
   import scm_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   logic [31:0] silence_ff;
   logic        win_full, win_push, win_pop, win_valid;
   window_type  push_data, front_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         silence_ff <= SILENCE_RESET;
      end else if (csr_valid) begin
         silence_ff <= csr_data;
      end
   end

   scm_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .win_full  (win_full),
      .win_push  (win_push),
      .win_data  (push_data)
   );

   scm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (win_push),
      .push_data   (push_data),
      .full        (win_full),
      .pop         (win_pop),
      .front_valid (win_valid),
      .front_data  (front_data)
   );

   scm_solver u_solver (
      .clock         (clock),
      .reset         (reset),
      .silence_limit (silence_ff),
      .win_valid     (win_valid),
      .win_data      (front_data),
      .win_pop       (win_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data)
   );

endmodule

### rtl/core/scm_accum.sv
// Front end: accumulates the three window sums and hands closed windows on.
module scm_accum
   import scm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   input  logic       win_full,
   output logic       win_push,
   output window_type win_data
);

   logic signed [SUM_W-1:0] cross_ff, cross_in;
   logic [SUM_W-1:0]        left_ff, left_in, right_ff, right_in;
   logic signed [31:0]      xp;
   logic [31:0]             lp, rp;
   logic signed [SUM_W:0]   xs;
   logic [SUM_W:0]          ls, rs;
   logic                    fire;

   assign req_ready = !win_full;
   assign fire      = req_valid && req_ready;

   always_comb begin
      xp = req_data.left_sample * req_data.right_sample;
      lp = req_data.left_sample * req_data.left_sample;
      rp = req_data.right_sample * req_data.right_sample;
      xs = {cross_ff[SUM_W-1], cross_ff} + {{(SUM_W-31){xp[31]}}, xp};
      ls = {1'b0, left_ff} + {{(SUM_W-31){1'b0}}, lp};
      rs = {1'b0, right_ff} + {{(SUM_W-31){1'b0}}, rp};
      // saturate instead of wrapping on over-long windows
      if (xs[SUM_W] != xs[SUM_W-1]) begin
         cross_in = xs[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         cross_in = xs[SUM_W-1:0];
      end
      left_in  = ls[SUM_W] ? {SUM_W{1'b1}} : ls[SUM_W-1:0];
      right_in = rs[SUM_W] ? {SUM_W{1'b1}} : rs[SUM_W-1:0];
   end

   assign win_push              = fire && req_data.last_in_window;
   assign win_data.cross_sum    = cross_in;
   assign win_data.left_energy  = left_in;
   assign win_data.right_energy = right_in;

   always_ff @(posedge clock) begin
      if (reset || win_push) begin
         cross_ff <= '0;
         left_ff  <= '0;
         right_ff <= '0;
      end else if (fire) begin
         cross_ff <= cross_in;
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

endmodule

### rtl/core/scm_queue.sv
// Short queue of closed windows between front and back end.
module scm_queue
   import scm_pkg::*;
#(
   parameter int DEPTH = 2
)(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  window_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       front_valid,
   output window_type front_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   window_type      slot_ff [DEPTH];
   logic [AW-1:0]   wr_ff, rd_ff;
   logic [CW-1:0]   count_ff;

   assign full        = (count_ff == CW'(DEPTH));
   assign front_valid = (count_ff != '0);
   assign front_data  = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("window queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !front_valid |-> !pop)
      else $error("window queue underflow");
`endif

endmodule

### rtl/core/scm_solver.sv
// Back end: energy product, cross-sum square, divide and square root for one closed window.
module scm_solver
   import scm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] silence_limit,
   input  logic        win_valid,
   input  window_type  win_data,
   output logic        win_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data
);

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_MULP = 8'b0000_0010,
      S_MULN = 8'b0000_0100,
      S_CHK  = 8'b0000_1000,
      S_DIV  = 8'b0001_0000,
      S_SQRT = 8'b0010_0000,
      S_FIN  = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   state_type         state_ff;
   window_type        win_ff;
   logic [SUM_W-1:0]  a_ff;
   logic [47:0]       b_ff;
   logic [PROD_W-1:0] acc_ff, acc_in, prod_ff;
   logic [NUM_W-1:0]  num_ff, rem_ff;
   logic [NUM_W:0]    dvs_ff;
   logic [30:0]       quo_ff;
   logic [15:0]       root_ff, cand, qc;
   logic [31:0]       sq;
   logic [4:0]        cnt_ff;
   logic [48:0]       pp;
   logic [SUM_W-1:0]  mag;
   logic              ge, is_silent, is_zero, is_sat;
   rsp_type           rsp_ff;

   always_comb begin
      pp        = a_ff * b_ff[47:40];
      acc_in    = {acc_ff[PROD_W-9:0], 8'b0} + {33'b0, pp};
      mag       = win_ff.cross_sum[SUM_W-1] ? (~win_ff.cross_sum + 1'b1) : win_ff.cross_sum;
      ge        = ({1'b0, rem_ff} >= dvs_ff);
      cand      = root_ff | (16'd1 << cnt_ff[3:0]);
      sq        = cand * cand;
      is_silent = (prod_ff < {50'b0, silence_limit});
      is_zero   = (prod_ff == '0);
      is_sat    = ({2'b0, num_ff} >= {prod_ff, 31'b0});
      qc        = (root_ff > 16'd32768) ? 16'd32768 : root_ff;
   end

   assign win_pop   = (state_ff == S_IDLE) && win_valid;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (win_valid) begin
                  win_ff   <= win_data;
                  a_ff     <= win_data.left_energy;
                  b_ff     <= {7'b0, win_data.right_energy};
                  acc_ff   <= '0;
                  cnt_ff   <= 5'd5;
                  state_ff <= S_MULP;
               end
            end
            S_MULP: begin
               if (cnt_ff == '0) begin
                  prod_ff  <= acc_in;
                  a_ff     <= mag;
                  b_ff     <= {7'b0, mag};
                  acc_ff   <= '0;
                  cnt_ff   <= 5'd5;
                  state_ff <= S_MULN;
               end else begin
                  acc_ff <= acc_in;
                  b_ff   <= {b_ff[39:0], 8'b0};
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_MULN: begin
               acc_ff <= acc_in;
               b_ff   <= {b_ff[39:0], 8'b0};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  num_ff   <= {acc_in[80:0], 30'b0};
                  state_ff <= S_CHK;
               end
            end
            S_CHK: begin
               if (is_silent || is_zero) begin
                  rsp_ff.correlation <= 16'sh7FFF;
                  rsp_ff.silent      <= is_silent;
                  state_ff           <= S_OUT;
               end else if (is_sat) begin
                  root_ff  <= 16'd32768;
                  state_ff <= S_FIN;
               end else begin
                  rem_ff   <= num_ff;
                  dvs_ff   <= {prod_ff, 30'b0};
                  quo_ff   <= '0;
                  cnt_ff   <= 5'd30;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (ge) begin
                  rem_ff <= rem_ff - dvs_ff[NUM_W-1:0];
               end
               quo_ff <= {quo_ff[29:0], ge};
               dvs_ff <= dvs_ff >> 1;
               if (cnt_ff == '0) begin
                  root_ff  <= '0;
                  cnt_ff   <= 5'd15;
                  state_ff <= S_SQRT;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            S_SQRT: begin
               if (sq <= {1'b0, quo_ff}) begin
                  root_ff <= cand;
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (win_ff.cross_sum[SUM_W-1]) begin
                  rsp_ff.correlation <= ~qc + 1'b1;
               end else begin
                  rsp_ff.correlation <= qc[15] ? 16'sh7FFF : qc;
               end
               rsp_ff.silent <= 1'b0;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               // hold the result until the transfer completes
               if (rsp_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_silent_is_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.silent |-> rsp_data.correlation == 16'sh7FFF)
      else $error("silent window without full-scale correlation");
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |=> state_ff == S_DIV || state_ff == S_SQRT)
      else $error("divide left to wrong state");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      win_pop |=> state_ff == S_MULP)
      else $error("window taken without starting multiply");
`endif

endmodule

### verif/testbench.sv
// Self-checking testbench for the stereo correlation meter.
module testbench;
   import scm_pkg::*;

   localparam longint CROSS_HI  = (64'sd1 <<< 40) - 1;
   localparam longint CROSS_LO  = -(64'sd1 <<< 40);
   localparam longint ENERGY_HI = (64'sd1 <<< 41) - 1;
   localparam int     CYCLE_LIMIT = 1000000;
   localparam int     SETTLE = 100;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_data;

   stereo_correlation_meter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   req_type pair_q[$];
   rsp_type coef_q[$];

   // shadow of the block's state
   longint      cross_acc;
   longint      left_acc;
   longint      right_acc;
   logic [31:0] quiet_limit;

   logic req_fire, rsp_fire, csr_fire;
   int   send_gap, recv_stall;
   bit   send_burst, recv_burst;
   int   errors, windows_seen, pairs_sent, cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Accumulate one pair; return 1 with the coefficient when it closes the window.
   function automatic bit accumulate_pair(input req_type p, output rsp_type res);
      longint       l, r, c;
      logic [127:0] prod, mag, num, trial;
      logic [127:0] lo_q, hi_q, mid;
      bit           quiet;
      l = longint'(p.left_sample);
      r = longint'(p.right_sample);
      c = cross_acc + l * r;
      cross_acc = c > CROSS_HI ? CROSS_HI : (c < CROSS_LO ? CROSS_LO : c);
      left_acc  = left_acc + l * l > ENERGY_HI ? ENERGY_HI : left_acc + l * l;
      right_acc = right_acc + r * r > ENERGY_HI ? ENERGY_HI : right_acc + r * r;
      res = '0;
      if (!p.last_in_window) return 0;
      prod  = 128'(left_acc) * 128'(right_acc);
      quiet = prod < 128'(quiet_limit);
      if (quiet || prod == 0) begin
         res.correlation = 16'sd32767;
      end else begin
         mag = cross_acc < 0 ? 128'(-cross_acc) : 128'(cross_acc);
         num = (mag * mag) << 30;
         lo_q = 0;
         hi_q = 32768;
         while (lo_q < hi_q) begin
            mid = (lo_q + hi_q + 1) >> 1;
            trial = prod * (mid * mid);
            if (trial <= num) lo_q = mid;
            else hi_q = mid - 1;
         end
         if (cross_acc < 0) res.correlation = -lo_q[15:0];
         else res.correlation = lo_q > 32767 ? 16'sd32767 : lo_q[15:0];
      end
      res.silent = quiet;
      cross_acc = 0;
      left_acc  = 0;
      right_acc = 0;
      return 1;
   endfunction

   function automatic int draw_wait(bit burst);
      return burst ? 0 : $urandom_range(0, 18);
   endfunction

   // sender: one pair per transfer, random gaps between items
   always @(negedge clock) begin
      if (reset) begin
         req_valid = 1'b0;
         send_gap = 0;
      end else if (!(req_valid && !req_fire)) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid = 1'b0;
         end else if (pair_q.size() > 0) begin
            req_data = pair_q.pop_front();
            req_valid = 1'b1;
            if ($urandom_range(0, 99) == 0) send_burst = ~send_burst;
            send_gap = draw_wait(send_burst);
         end else begin
            req_valid = 1'b0;
         end
      end
   end

   // receiver: random stall before taking each result
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready = 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_fire) begin
            if ($urandom_range(0, 15) == 0) recv_burst = ~recv_burst;
            recv_stall = draw_wait(recv_burst);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready = 1'b0;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // monitor: predict on accepted pairs, check on accepted results
   always @(posedge clock) begin
      rsp_type want, got;
      req_fire <= !reset && req_valid && req_ready;
      rsp_fire <= !reset && rsp_valid && rsp_ready;
      csr_fire <= !reset && csr_valid && csr_ready;
      if (reset) begin
         cross_acc = 0;
         left_acc = 0;
         right_acc = 0;
         quiet_limit = SILENCE_RESET;
      end else begin
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[stereo_correlation_meter] ERROR");
            $finish;
         end
         if (csr_valid && csr_ready) quiet_limit = csr_data;
         if (req_valid && req_ready) begin
            pairs_sent++;
            if (accumulate_pair(req_data, want)) coef_q.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            windows_seen++;
            if (coef_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result %0d silent %0d",
                                          got.correlation, got.silent);
            end else begin
               want = coef_q.pop_front();
               if (got.correlation !== want.correlation || got.silent !== want.silent) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: expected %0d silent %0d, got %0d silent %0d",
                              want.correlation, want.silent, got.correlation, got.silent);
               end
            end
         end
      end
   end

   function automatic void add_pair(int l, int r, bit last);
      req_type p;
      p.left_sample = l[15:0];
      p.right_sample = r[15:0];
      p.last_in_window = last;
      pair_q.push_back(p);
   endfunction

   task automatic drain_all;
      wait (pair_q.size() == 0 && !req_valid && coef_q.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_limit(logic [31:0] v);
      @(negedge clock);
      csr_data = v;
      csr_valid = 1'b1;
      do @(negedge clock); while (!csr_fire);
      csr_valid = 1'b0;
   endtask

   // random window: shape picks how left and right relate
   task automatic random_window(int len);
      int shape, amp, l, r;
      shape = $urandom_range(0, 4);
      amp = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 32768;
      for (int i = 0; i < len; i++) begin
         l = int'($urandom_range(0, 2 * amp - 1)) - amp;
         case (shape)
            0: r = l;
            1: r = l == -32768 ? 32767 : -l;
            2: r = l / 2 + int'($urandom_range(0, 63)) - 32;
            default: r = int'($urandom_range(0, 2 * amp - 1)) - amp;
         endcase
         add_pair(l, r, i == len - 1);
      end
   endtask

   initial begin
      int limits[4];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_data = '0;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      csr_fire = 1'b0;
      send_burst = 1'b0;
      recv_burst = 1'b0;
      errors = 0;
      windows_seen = 0;
      pairs_sent = 0;
      cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes at the default limit
      add_pair(32767, 32767, 1);
      add_pair(-32768, -32768, 1);
      add_pair(-32768, 32767, 1);
      add_pair(32767, -32768, 1);
      add_pair(0, 0, 1);
      add_pair(1, 1, 1);
      add_pair(32767, 0, 1);
      add_pair(0, -32768, 1);
      add_pair(1000, 0, 0);
      add_pair(0, 1000, 1);
      add_pair(20000, -5, 0);
      add_pair(-3, 30000, 1);
      drain_all();

      // zero energy with the limit at zero is not silent
      write_limit(32'd0);
      add_pair(0, 0, 1);
      add_pair(1, -1, 1);
      add_pair(0, 0, 0);
      add_pair(0, 0, 1);
      drain_all();

      // largest limit: only low-energy windows read silent
      write_limit(32'hFFFF_FFFF);
      add_pair(32767, 32767, 1);
      add_pair(-32768, 32767, 1);
      add_pair(5, 7, 1);
      drain_all();

      // over-long window saturates the cross sum
      write_limit(SILENCE_RESET);
      for (int i = 0; i < 1100; i++) add_pair(-32768, -32768, i == 1099);
      drain_all();

      // random phases under several limits
      limits = '{0, 32'hFFFF_FFFF, 32'd1000, 32'd1152921505};
      for (int ph = 0; ph < 6; ph++) begin
         write_limit(ph < 4 ? limits[ph] : $urandom());
         for (int n = 0; n < 100;) begin
            int len;
            len = $urandom_range(0, 9) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 12);
            random_window(len);
            n += len;
         end
         drain_all();
      end

      $display("covered %0d sample pairs and %0d windows across several limit settings,",
               pairs_sent, windows_seen);
      $display("including silent, zero-energy and saturated windows");
      if (errors == 0 && coef_q.size() == 0) begin
         $display("[stereo_correlation_meter] OK");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, coef_q.size());
         $display("[stereo_correlation_meter] ERROR");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/scm_pkg.sv
rtl/core/scm_accum.sv
rtl/core/scm_queue.sv
rtl/core/scm_solver.sv
rtl/core/stereo_correlation_meter.sv
verif/testbench.sv
